/* sv/sma_pkg.sv */
// Shared types and constants for the simple moving average block.
package sma_pkg;

    localparam int DEF_MAX_WINDOW = 64;
    localparam int SAMPLE_W       = 32;
    localparam int WLEN_W         = 7;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd3;

    // One input word as it travels from the front queue to the back end.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       series_start;
    } t_sma_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_LOAD
    } t_sma_state;

endpackage

/* sv/simple_moving_average.sv */
// Top level of the simple moving average (boxcar) filter over Q16.16 samples.
//
//   Channel  | Direction | Handshake               | Word
//   ---------+-----------+-------------------------+--------------------------------
//   input    | in        | i_valid / o_stall       | i_sample, i_series_start
//   result   | out       | o_valid / i_stall       | o_average
//   config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (window length)
//
// A word that fills or keeps a full window then goes through the one-bit-per-cycle divider
// on the window sum and on to the result register.
// A word that yields no result takes the ring read, then the ring write and update.
// Reset clears the window state and sets the window length to 3; the ring needs no clearing.
// A stalled result is held while the two-entry input queue keeps taking words until it is full.
module simple_moving_average #(
    parameter int MAX_WINDOW = sma_pkg::DEF_MAX_WINDOW
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [sma_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_series_start,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [sma_pkg::SAMPLE_W-1:0]  o_average,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sma_pkg::WLEN_W-1:0]           i_cfg_data
);
    import sma_pkg::*;

    logic [WLEN_W-1:0] r_window_len;
    logic              w_cfg_write;
    t_sma_item         w_in_item;
    t_sma_item         w_q_item;
    logic              w_q_valid;
    logic              w_q_pop;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WLEN_RESET;
        end else if (w_cfg_write) begin
            r_window_len <= i_cfg_data;
        end
    end

    assign w_in_item.sample       = i_sample;
    assign w_in_item.series_start = i_series_start;

    sma_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (w_in_item),
        .o_item_valid (w_q_valid),
        .o_item       (w_q_item),
        .i_pop        (w_q_pop)
    );

    sma_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_window_len (r_window_len),
        .i_cfg_write  (w_cfg_write),
        .i_item_valid (w_q_valid),
        .i_item       (w_q_item),
        .o_pop        (w_q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_average    (o_average)
    );

endmodule

/* sv/sma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/sma_front.sv */
// Front end: two-entry queue that takes input words and hands them to the back end.
module sma_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sma_pkg::t_sma_item  i_item,
    output logic                o_item_valid,
    output sma_pkg::t_sma_item  o_item,
    input  logic                i_pop
);
    import sma_pkg::*;

    t_sma_item   r_entry [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_push;
    logic        w_pop;

    assign o_stall      = (r_count == 2'd2);
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = i_pop && (r_count != 2'd0);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("front queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |-> !w_pop)
        else $error("front queue popped while empty");

    a_push_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("front queue count missed a push");

endmodule

/* sv/sma_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module sma_div #(
    parameter int DIVIDEND_W = 38,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_fits;

    // The remainder stays below the divisor, so the shifted value needs one extra bit.
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_fits  = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with no steps left");

endmodule

/* sv/sma_back.sv */
// Back end: window bookkeeping, sample ring, divide sequencing and result register.
module sma_back #(
    parameter int MAX_WINDOW = sma_pkg::DEF_MAX_WINDOW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sma_pkg::WLEN_W-1:0]   i_window_len,
    input  logic                         i_cfg_write,
    input  logic                         i_item_valid,
    input  sma_pkg::t_sma_item           i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [sma_pkg::SAMPLE_W-1:0] o_average
);
    import sma_pkg::*;

    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);

    t_sma_state                  r_state;
    t_sma_state                  n_state;
    logic [SLOT_W-1:0]           r_write_slot;
    logic [LEN_W-1:0]            r_fill;
    logic [LEN_W-1:0]            n_fill;
    logic signed [SUM_W-1:0]     r_sum;
    logic signed [SUM_W-1:0]     n_sum;
    logic [SLOT_W-1:0]           r_slot;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic                        r_neg;
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_average;

    logic [LEN_W-1:0]            w_len;
    logic [SLOT_W-1:0]           w_base_slot;
    logic [SLOT_W-1:0]           w_slot;
    logic [LEN_W-1:0]            w_slot_inc;
    logic                        w_full;
    logic                        w_emit;
    logic [SAMPLE_W-1:0]         w_ram_rdata;
    logic signed [SUM_W-1:0]     w_old_ext;
    logic signed [SUM_W-1:0]     w_new_ext;
    logic [SUM_W-1:0]            w_magnitude;
    logic                        w_pop;
    logic                        w_ram_we;
    logic                        w_div_start;
    logic                        w_load;
    logic                        w_div_done;
    logic [SUM_W-1:0]            w_quotient;
    logic [SAMPLE_W-1:0]         w_q_low;

    // A period of zero acts as one; a period above the ring size acts as the ring size.
    always_comb begin
        if (i_window_len == '0) begin
            w_len = LEN_W'(1);
        end else if (int'(i_window_len) > MAX_WINDOW) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = LEN_W'(i_window_len);
        end
    end

    // Slot for a word leaving the queue; a series start begins again at slot zero.
    assign w_base_slot = i_item.series_start ? '0 : r_write_slot;
    assign w_slot      = (LEN_W'(w_base_slot) >= w_len) ? '0 : w_base_slot;

    assign w_full     = (r_fill >= w_len);
    assign w_slot_inc = LEN_W'(r_slot) + LEN_W'(1);
    assign w_old_ext  = signed'({{(SUM_W-SAMPLE_W){w_ram_rdata[SAMPLE_W-1]}}, w_ram_rdata});
    assign w_new_ext  = signed'({{(SUM_W-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample});
    assign n_fill     = w_full ? w_len : (r_fill + LEN_W'(1));
    assign n_sum      = r_sum - (w_full ? w_old_ext : '0) + w_new_ext;
    assign w_emit     = (n_fill == w_len);
    assign w_magnitude = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = w_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        w_pop       = 1'b0;
        w_ram_we    = 1'b0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_pop = i_item_valid;
            end
            S_UPDATE: begin
                w_ram_we    = 1'b1;
                w_div_start = w_emit;
            end
            S_LOAD: begin
                w_load = !r_out_valid || !i_stall;
            end
            default: begin
                w_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_write_slot <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_write) begin
                r_write_slot <= '0;
                r_fill       <= '0;
                r_sum        <= '0;
            end else if (w_pop && i_item.series_start) begin
                r_fill <= '0;
                r_sum  <= '0;
            end else if (w_ram_we) begin
                r_fill       <= n_fill;
                r_sum        <= n_sum;
                r_write_slot <= (w_slot_inc >= w_len) ? '0 : SLOT_W'(w_slot_inc);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_slot   <= w_slot;
            r_sample <= i_item.sample;
        end
        if (w_div_start) begin
            r_neg <= n_sum[SUM_W-1];
        end
        if (w_load) begin
            r_average <= r_neg ? signed'(-w_q_low) : signed'(w_q_low);
        end
    end

    assign w_q_low = w_quotient[SAMPLE_W-1:0];

    sma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_re    (w_pop),
        .i_raddr (w_slot),
        .o_rdata (w_ram_rdata)
    );

    sma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_magnitude),
        .i_divisor  (w_len),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign o_pop     = w_pop;
    assign o_valid   = r_out_valid;
    assign o_average = r_average;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_len)
        else $error("fill count beyond the window length");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(r_write_slot) < w_len)
        else $error("write slot beyond the window length");

    a_result_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_fill == w_len))
        else $error("result produced from a partial window");

    a_update_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> $past(w_pop))
        else $error("window update without a word taken from the queue");

endmodule
